// ===== rtl/core/vthc_pkg.sv =====
// Shared types and constants for the voxel to hexahedron corner block.
package vthc_pkg;

  localparam int DIM_W   = 11;
  localparam int MIN_W   = 21;
  localparam int SIZE_W  = 13;
  localparam int COORD_W = 32;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 21;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [31:0] EMPTY_DENSITY = 32'h8000_0000;
  localparam logic [2:0]  LAST_CORNER   = 3'd7;

  localparam logic [IDX_W-1:0] REG_DIM_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_DIM_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_X  = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_Y  = 3'd3;
  localparam logic [IDX_W-1:0] REG_MIN_Z  = 3'd4;
  localparam logic [IDX_W-1:0] REG_SIZE_X = 3'd5;
  localparam logic [IDX_W-1:0] REG_SIZE_Y = 3'd6;
  localparam logic [IDX_W-1:0] REG_SIZE_Z = 3'd7;

  typedef struct packed {
    logic signed [31:0] density;
    logic               grid_start;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic [2:0]                corner;
    logic                      last_corner;
  } out_beat_t;

  typedef struct packed {
    logic [DIM_W-1:0]         dim_x;
    logic [DIM_W-1:0]         dim_y;
    logic signed [MIN_W-1:0]  min_x;
    logic signed [MIN_W-1:0]  min_y;
    logic signed [MIN_W-1:0]  min_z;
    logic [SIZE_W-1:0]        size_x;
    logic [SIZE_W-1:0]        size_y;
    logic [SIZE_W-1:0]        size_z;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } base_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/core/vthc_ifs.sv =====
// Valid/ready stream interfaces for the voxel input and corner output channels.
interface vthc_in_if;
  import vthc_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vthc_out_if;
  import vthc_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/vthc_front.sv =====
// Front end: grid counters, empty voxel filter and base corner computation.
module vthc_front #(
  parameter int MAX_DIM = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vthc_pkg::cfg_t       cfg,
  vthc_in_if.sink              in_s,
  input  vthc_pkg::fifo_stat_t stat,
  output logic                 push,
  output vthc_pkg::base_t      push_data
);
  import vthc_pkg::*;

  localparam int CW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CMPW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int PW   = CW + SIZE_W;

  logic [CW-1:0] cnt_x_r, cnt_y_r, cnt_z_r;
  logic [CW-1:0] cnt_x_nxt, cnt_y_nxt, cnt_z_nxt;
  logic [CW-1:0] cur_x, cur_y, cur_z;
  logic [CW:0]   nx, ny, nz;

  logic          s1_v_r, s1_v_nxt;
  logic          s1_empty_r;
  logic [CW-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic          s2_v_r, s2_v_nxt;
  base_t         s2_r;
  base_t         s2_nxt;

  logic accept, s1_go, s2_free, s2_load;
  logic [PW-1:0] prod_x, prod_y, prod_z;

  assign push    = s2_v_r && !stat.full;
  assign s2_free = !s2_v_r || push;
  assign s1_go   = s1_v_r && (s1_empty_r || s2_free);
  assign s2_load = s1_go && !s1_empty_r;
  assign in_s.ready = !s1_v_r || s1_go;
  assign accept  = in_s.valid && in_s.ready;
  assign push_data = s2_r;

  always_comb begin
    cur_x = in_s.data.grid_start ? '0 : cnt_x_r;
    cur_y = in_s.data.grid_start ? '0 : cnt_y_r;
    cur_z = in_s.data.grid_start ? '0 : cnt_z_r;
    nx = {1'b0, cur_x} + (CW+1)'(1);
    ny = {1'b0, cur_y} + (CW+1)'(1);
    nz = {1'b0, cur_z} + (CW+1)'(1);
    cnt_x_nxt = cnt_x_r;
    cnt_y_nxt = cnt_y_r;
    cnt_z_nxt = cnt_z_r;
    if (accept) begin
      cnt_y_nxt = cur_y;
      cnt_z_nxt = cur_z;
      if (CMPW'(nx) >= CMPW'(cfg.dim_x) || nx >= (CW+1)'(MAX_DIM)) begin
        cnt_x_nxt = '0;
        if (CMPW'(ny) >= CMPW'(cfg.dim_y) || ny >= (CW+1)'(MAX_DIM)) begin
          cnt_y_nxt = '0;
          cnt_z_nxt = (nz >= (CW+1)'(MAX_DIM)) ? '0 : nz[CW-1:0];
        end else begin
          cnt_y_nxt = ny[CW-1:0];
        end
      end else begin
        cnt_x_nxt = nx[CW-1:0];
      end
    end
  end

  always_comb begin
    prod_x = PW'(s1_x_r) * PW'(cfg.size_x);
    prod_y = PW'(s1_y_r) * PW'(cfg.size_y);
    prod_z = PW'(s1_z_r) * PW'(cfg.size_z);
    s2_nxt.x = {{(COORD_W-MIN_W){cfg.min_x[MIN_W-1]}}, cfg.min_x}
             + {{(COORD_W-PW){1'b0}}, prod_x};
    s2_nxt.y = {{(COORD_W-MIN_W){cfg.min_y[MIN_W-1]}}, cfg.min_y}
             + {{(COORD_W-PW){1'b0}}, prod_y};
    s2_nxt.z = {{(COORD_W-MIN_W){cfg.min_z[MIN_W-1]}}, cfg.min_z}
             + {{(COORD_W-PW){1'b0}}, prod_z};
    s1_v_nxt = accept || (s1_v_r && !s1_go);
    s2_v_nxt = (s2_v_r && !push) || s2_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_x_r <= '0;
      cnt_y_r <= '0;
      cnt_z_r <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      cnt_x_r <= cnt_x_nxt;
      cnt_y_r <= cnt_y_nxt;
      cnt_z_r <= cnt_z_nxt;
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_empty_r <= (in_s.data.density == EMPTY_DENSITY);
      s1_x_r <= cur_x;
      s1_y_r <= cur_y;
      s1_z_r <= cur_z;
    end
    if (s2_load) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

// ===== rtl/core/vthc_fifo.sv =====
// Short queue of base corners between the front and back ends.
module vthc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  vthc_pkg::base_t      push_data,
  input  logic                 pop,
  output vthc_pkg::base_t      pop_data,
  output vthc_pkg::fifo_stat_t stat
);
  import vthc_pkg::*;

  base_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_PTR_W:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("queue read while empty");

endmodule

// ===== rtl/core/vthc_back.sv =====
// Back end: corner sequencer and registered output stage.
module vthc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vthc_pkg::cfg_t       cfg,
  input  vthc_pkg::fifo_stat_t stat,
  input  vthc_pkg::base_t      pop_data,
  output logic                 pop,
  vthc_out_if.source           out_m
);
  import vthc_pkg::*;

  logic      b_v_r, b_v_nxt;
  base_t     base_r;
  logic [2:0] k_r, k_nxt;
  logic      out_v_r, out_v_nxt;
  out_beat_t out_r, out_nxt;
  logic      emit, last;

  assign emit = b_v_r && (!out_v_r || out_m.ready);
  assign last = (k_r == LAST_CORNER);
  assign pop  = !stat.empty && (!b_v_r || (emit && last));

  assign out_m.valid = out_v_r;
  assign out_m.data  = out_r;

  always_comb begin
    out_nxt.vertex_x = base_r.x
      + ((k_r[0] ^ k_r[1]) ? {{(COORD_W-SIZE_W){1'b0}}, cfg.size_x} : '0);
    out_nxt.vertex_y = base_r.y
      + (k_r[2] ? {{(COORD_W-SIZE_W){1'b0}}, cfg.size_y} : '0);
    out_nxt.vertex_z = base_r.z
      - (k_r[1] ? {{(COORD_W-SIZE_W){1'b0}}, cfg.size_z} : '0);
    out_nxt.corner      = k_r;
    out_nxt.last_corner = last;
    k_nxt     = emit ? k_r + 3'd1 : k_r;
    b_v_nxt   = pop ? 1'b1 : ((emit && last) ? 1'b0 : b_v_r);
    out_v_nxt = emit ? 1'b1 : (out_m.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r   <= 1'b0;
      k_r     <= '0;
      out_v_r <= 1'b0;
    end else begin
      b_v_r   <= b_v_nxt;
      k_r     <= k_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      base_r <= pop_data;
    end
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  a_corner_step: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !last) |=> (b_v_r && k_r == $past(k_r) + 3'd1))
    else $error("corner sequence broken mid voxel");

  a_idle_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !b_v_r |-> (k_r == '0))
    else $error("corner counter not at zero between voxels");

endmodule

// ===== rtl/core/voxel_to_hexahedron_corners.sv =====
// Top level: configuration registers, front end, queue and corner back end.
// Voxel densities enter one beat per cycle, while ready is high, in x, y, z
// scan order. An empty voxel (density 0x80000000) only advances the grid
// counters and gives no output; a filled voxel gives eight corner beats, v0
// to v7, one per cycle unless the output stalls, at a rate set by the corner
// sequencer feeding the single output register. Empty voxels pass one per
// cycle, even with the queue full, unless a blocked filled voxel holds stage
// 1. Stage 1, stage 2, the queue and the base register lie before the output
// register. Configuration writes take effect in the next cycle; the user must
// make them only while the block is idle, which the block does not enforce.
module voxel_to_hexahedron_corners #(
  parameter int MAX_DIM = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vthc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [vthc_pkg::DATA_W-1:0]   cfg_data,
  vthc_in_if.sink                       in_s,
  vthc_out_if.source                    out_m
);
  import vthc_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  fifo_stat_t stat;
  logic       push, pop;
  base_t      push_data, pop_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DIM_X:  cfg_nxt.dim_x  = cfg_data[DIM_W-1:0];
        REG_DIM_Y:  cfg_nxt.dim_y  = cfg_data[DIM_W-1:0];
        REG_MIN_X:  cfg_nxt.min_x  = cfg_data[MIN_W-1:0];
        REG_MIN_Y:  cfg_nxt.min_y  = cfg_data[MIN_W-1:0];
        REG_MIN_Z:  cfg_nxt.min_z  = cfg_data[MIN_W-1:0];
        REG_SIZE_X: cfg_nxt.size_x = cfg_data[SIZE_W-1:0];
        REG_SIZE_Y: cfg_nxt.size_y = cfg_data[SIZE_W-1:0];
        REG_SIZE_Z: cfg_nxt.size_z = cfg_data[SIZE_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dim_x  <= DIM_W'(1);
      cfg_r.dim_y  <= DIM_W'(1);
      cfg_r.min_x  <= '0;
      cfg_r.min_y  <= '0;
      cfg_r.min_z  <= '0;
      cfg_r.size_x <= SIZE_W'(1);
      cfg_r.size_y <= SIZE_W'(1);
      cfg_r.size_z <= SIZE_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  vthc_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_s      (in_s),
    .stat      (stat),
    .push      (push),
    .push_data (push_data)
  );

  vthc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (stat)
  );

  vthc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .stat     (stat),
    .pop_data (pop_data),
    .pop      (pop),
    .out_m    (out_m)
  );

endmodule

// ===== tb/corner_checker.sv =====
// Corner checker: tracks geometry and grid position, predicts corner beats and compares them.
module corner_checker #(
  parameter int MAX_DIM = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [vthc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [vthc_pkg::DATA_W-1:0] cfg_data,
  input  logic                        voxel_valid,
  input  logic                        voxel_ready,
  input  vthc_pkg::in_beat_t          voxel,
  input  logic                        corner_valid,
  input  logic                        corner_ready,
  input  vthc_pkg::out_beat_t         corner_beat,
  output int                          fail_count,
  output int                          pending
);
  import vthc_pkg::*;

  cfg_t      geom;
  int        grid_x;
  int        grid_y;
  int        grid_z;
  int        errors;
  out_beat_t expected_corners[$];

  function automatic void step_grid();
    int nx;
    int ny;
    nx = grid_x + 1;
    if (nx >= int'(geom.dim_x) || nx >= MAX_DIM) begin
      grid_x = 0;
      ny = grid_y + 1;
      if (ny >= int'(geom.dim_y) || ny >= MAX_DIM) begin
        grid_y = 0;
        grid_z = (grid_z + 1 >= MAX_DIM) ? 0 : grid_z + 1;
      end else begin
        grid_y = ny;
      end
    end else begin
      grid_x = nx;
    end
  endfunction

  function automatic void predict_corners(input in_beat_t vox);
    longint    px;
    longint    py;
    longint    pz;
    logic [2:0] k;
    out_beat_t c;
    if (vox.grid_start) begin
      grid_x = 0;
      grid_y = 0;
      grid_z = 0;
    end
    if (vox.density != EMPTY_DENSITY) begin
      px = longint'(geom.min_x) + longint'(grid_x) * longint'({1'b0, geom.size_x});
      py = longint'(geom.min_y) + longint'(grid_y) * longint'({1'b0, geom.size_y});
      pz = longint'(geom.min_z) + longint'(grid_z) * longint'({1'b0, geom.size_z});
      for (int i = 0; i < 8; i++) begin
        k = 3'(i);
        c.vertex_x    = 32'(px + ((k[0] ^ k[1]) ? longint'({1'b0, geom.size_x}) : 64'sd0));
        c.vertex_y    = 32'(py + (k[2] ? longint'({1'b0, geom.size_y}) : 64'sd0));
        c.vertex_z    = 32'(pz - (k[1] ? longint'({1'b0, geom.size_z}) : 64'sd0));
        c.corner      = k;
        c.last_corner = (k == LAST_CORNER);
        expected_corners.insert(expected_corners.size(), c);
      end
    end
    step_grid();
  endfunction

  function automatic void check_corner(input out_beat_t got);
    out_beat_t want;
    logic      bad;
    if (expected_corners.size() == 0) begin
      $display("%0t: corner beat with nothing expected: x %0d y %0d z %0d corner %0d last %0b",
               $time, got.vertex_x, got.vertex_y, got.vertex_z, got.corner, got.last_corner);
      errors++;
      return;
    end
    want = expected_corners.pop_front();
    bad  = 1'b0;
    if (got.vertex_x !== want.vertex_x) begin
      $display("%0t: vertex_x expected %0d actual %0d", $time, want.vertex_x, got.vertex_x);
      bad = 1'b1;
    end
    if (got.vertex_y !== want.vertex_y) begin
      $display("%0t: vertex_y expected %0d actual %0d", $time, want.vertex_y, got.vertex_y);
      bad = 1'b1;
    end
    if (got.vertex_z !== want.vertex_z) begin
      $display("%0t: vertex_z expected %0d actual %0d", $time, want.vertex_z, got.vertex_z);
      bad = 1'b1;
    end
    if (got.corner !== want.corner) begin
      $display("%0t: corner expected %0d actual %0d", $time, want.corner, got.corner);
      bad = 1'b1;
    end
    if (got.last_corner !== want.last_corner) begin
      $display("%0t: last_corner expected %0b actual %0b", $time, want.last_corner,
               got.last_corner);
      bad = 1'b1;
    end
    if (bad) errors++;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      geom.dim_x  = DIM_W'(1);
      geom.dim_y  = DIM_W'(1);
      geom.min_x  = '0;
      geom.min_y  = '0;
      geom.min_z  = '0;
      geom.size_x = SIZE_W'(1);
      geom.size_y = SIZE_W'(1);
      geom.size_z = SIZE_W'(1);
      grid_x = 0;
      grid_y = 0;
      grid_z = 0;
      expected_corners.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DIM_X:  geom.dim_x  = cfg_data[DIM_W-1:0];
          REG_DIM_Y:  geom.dim_y  = cfg_data[DIM_W-1:0];
          REG_MIN_X:  geom.min_x  = cfg_data[MIN_W-1:0];
          REG_MIN_Y:  geom.min_y  = cfg_data[MIN_W-1:0];
          REG_MIN_Z:  geom.min_z  = cfg_data[MIN_W-1:0];
          REG_SIZE_X: geom.size_x = cfg_data[SIZE_W-1:0];
          REG_SIZE_Y: geom.size_y = cfg_data[SIZE_W-1:0];
          REG_SIZE_Z: geom.size_z = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (corner_valid && corner_ready) check_corner(corner_beat);
      if (voxel_valid && voxel_ready) predict_corners(voxel);
    end
    fail_count <= errors;
    pending    <= expected_corners.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: clock, reset, voxel stimulus, corner receiver, watchdog and verdict.
module testbench;
  import vthc_pkg::*;

  localparam int MAX_DIM     = 1024;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 12;
  localparam int HOLD_BEAT   = 600;
  localparam int HOLD_CYCLES = 300;
  localparam int RUN_LEN     = 70;
  localparam int SWEEP_LEN   = 24;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;
  logic              no_gaps = 1'b0;
  int                fail_count;
  int                pending;
  int                stall_cycles = 0;

  vthc_in_if  voxel_if ();
  vthc_out_if corner_if ();

  voxel_to_hexahedron_corners #(
    .MAX_DIM (MAX_DIM)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_s      (voxel_if),
    .out_m     (corner_if)
  );

  corner_checker #(
    .MAX_DIM (MAX_DIM)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .voxel_valid  (voxel_if.valid),
    .voxel_ready  (voxel_if.ready),
    .voxel        (voxel_if.data),
    .corner_valid (corner_if.valid),
    .corner_ready (corner_if.ready),
    .corner_beat  (corner_if.data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (voxel_if.valid && voxel_if.ready) || (corner_if.valid && corner_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic load_geometry(input int dx, input int dy, input int mx, input int my,
                               input int mz, input int sx, input int sy, input int sz);
    write_reg(REG_DIM_X,  DATA_W'(dx));
    write_reg(REG_DIM_Y,  DATA_W'(dy));
    write_reg(REG_MIN_X,  DATA_W'(mx));
    write_reg(REG_MIN_Y,  DATA_W'(my));
    write_reg(REG_MIN_Z,  DATA_W'(mz));
    write_reg(REG_SIZE_X, DATA_W'(sx));
    write_reg(REG_SIZE_Y, DATA_W'(sy));
    write_reg(REG_SIZE_Z, DATA_W'(sz));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drop valid, drain all corners, then let in-flight empty voxels finish
  task automatic settle();
    voxel_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_voxel(input logic [31:0] density, input logic gs);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      voxel_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    voxel_if.valid <= 1'b1;
    voxel_if.data  <= '{density: density, grid_start: gs};
    do @(posedge clk); while (!(voxel_if.valid && voxel_if.ready));
  endtask

  function automatic logic [31:0] pick_density(input int empty_odds);
    return ($urandom_range(0, empty_odds - 1) == 0) ? EMPTY_DENSITY : 32'($urandom);
  endfunction

  task automatic run_scan(input int n, input int empty_odds, input int filled_odds);
    logic [31:0] d;
    for (int i = 0; i < n; i++) begin
      if (filled_odds > 1 && $urandom_range(0, filled_odds - 1) != 0) d = EMPTY_DENSITY;
      else d = pick_density(empty_odds);
      send_voxel(d, (i == 0) || ($urandom_range(0, 23) == 0 && filled_odds <= 1));
    end
  endtask

  task automatic run_random(input int n);
    int dx;
    int dy;
    dx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 6);
    dy = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 6);
    settle();
    load_geometry(dx, dy, $urandom, $urandom, $urandom,
                  ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8191),
                  ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8191),
                  ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8191));
    run_scan(n, 4, 1);
  endtask

  task automatic run_sweep(input int dx, input int dy);
    settle();
    load_geometry(dx, dy, $urandom, $urandom, $urandom, $urandom_range(0, 8191),
                  $urandom_range(0, 8191), $urandom_range(0, 8191));
    run_scan(SWEEP_LEN, 8, 16);
  endtask

  initial begin : receiver
    int wait_n;
    int beats;
    beats = 0;
    corner_if.ready <= 1'b0;
    forever begin
      wait_n = no_gaps ? 0 : $urandom_range(0, 6);
      if (beats == HOLD_BEAT) wait_n = HOLD_CYCLES;
      if (wait_n > 0) begin
        corner_if.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      corner_if.ready <= 1'b1;
      do @(posedge clk); while (!(corner_if.valid && corner_if.ready));
      beats++;
    end
  end

  initial begin : stimulus
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    voxel_if.valid <= 1'b0;
    voxel_if.data  <= '0;
    no_gaps = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry
    send_voxel(32'd100, 1'b1);
    send_voxel(EMPTY_DENSITY, 1'b0);
    send_voxel(32'hFFFF_FFFF, 1'b0);

    settle();
    load_geometry(3, 2, -5, 7, 100, 4096, 3, 1);
    send_voxel(32'h7FFF_FFFF, 1'b1);
    send_voxel(32'h8000_0001, 1'b0);
    send_voxel(32'h0000_0000, 1'b0);
    send_voxel(EMPTY_DENSITY, 1'b0);
    send_voxel(32'h0000_0001, 1'b0);
    send_voxel(32'hFFFF_FFFF, 1'b0);
    send_voxel(32'h5555_5555, 1'b0);
    send_voxel(32'hAAAA_AAAA, 1'b1);
    send_voxel(EMPTY_DENSITY, 1'b0);
    send_voxel(32'h0000_0007, 1'b0);

    // zero dims, most negative corner, widest sizes
    settle();
    load_geometry(0, 0, -1048576, -1048576, -1048576, 8191, 8191, 8191);
    send_voxel(32'h1234_5678, 1'b1);
    send_voxel(32'h8765_4321, 1'b0);
    send_voxel(EMPTY_DENSITY, 1'b0);
    send_voxel(32'h0F0F_0F0F, 1'b0);

    // oversized dims, most positive corner, zero sizes
    settle();
    load_geometry(2047, 2047, 1048575, 1048575, 1048575, 0, 0, 0);
    send_voxel(32'hF0F0_F0F0, 1'b1);
    send_voxel(32'h0000_0002, 1'b0);
    send_voxel(EMPTY_DENSITY, 1'b0);
    send_voxel(32'h7FFF_FFFE, 1'b0);

    run_random(RUN_LEN);
    run_random(RUN_LEN);
    no_gaps = 1'b1;
    run_random(RUN_LEN);
    run_sweep(2047, 1);
    run_sweep(1, 2047);
    run_sweep(0, 1);
    no_gaps = 1'b0;
    run_random(RUN_LEN);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/vthc_pkg.sv
rtl/core/vthc_ifs.sv
rtl/core/vthc_front.sv
rtl/core/vthc_fifo.sv
rtl/core/vthc_back.sv
rtl/core/voxel_to_hexahedron_corners.sv
tb/corner_checker.sv
tb/testbench.sv
